// ===== hw/rtl/bst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the binary semaphore table.
// Used by the compare unit, the top level and the port checker; depends on nothing.
package bst_pkg;

    // Width of the id fields on the ports.
    localparam int PORT_ID_W = 16;
    // Width at which ids are compared, wide enough for any legal ID_WIDTH.
    localparam int CMP_W = 32;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_DOWN  = 2'd2,
        FN_UP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_WOULD_BLOCK = 3'd3,
        ST_EXHAUSTED   = 3'd4
    } t_status;

endpackage

// ===== hw/rtl/bst_cmp.sv =====
`timescale 1ns / 1ps
// Shared compare unit used once per scanned table entry.
// Depends on bst_pkg for the operation codes and the compare width.
module bst_cmp #(
    parameter int ID_WIDTH = 16
) (
    input  bst_pkg::t_func                  i_func,
    input  logic [bst_pkg::PORT_ID_W-1:0]   i_tgt,
    input  logic                            i_occ,
    input  logic [ID_WIDTH-1:0]             i_data,
    output logic                            o_hit
);

    localparam int CW = bst_pkg::CMP_W;

    logic [CW-1:0] data_w;
    logic [CW-1:0] tgt_w;

    assign data_w = CW'(i_data);
    assign tgt_w  = CW'(i_tgt);

    // An alloc looks for an empty entry; the other operations look for an
    // occupied entry holding the named id. Id zero names nothing.
    always_comb begin
        case (i_func)
            bst_pkg::FN_ALLOC: o_hit = !i_occ;
            default:           o_hit = i_occ && (tgt_w != '0) && (tgt_w == data_w);
        endcase
    end

endmodule

// ===== hw/rtl/binary_semaphore_table.sv =====
`timescale 1ns / 1ps
// Top level of the binary semaphore table: request sequencer, id memory and
// result register. Depends on bst_pkg and instantiates bst_cmp.
//
// Usage. A request item (i_func, i_sem_id) is accepted at a rising edge with
// i_in_valid high and o_in_stall low. Operations are alloc, free, down and up.
// Each request yields exactly one result item (o_status, o_new_id, o_wake),
// taken at an edge with o_out_valid high and i_out_stall low.
// The block holds one request at a time. It scans the table one entry per
// cycle through the single read port of the id memory and the shared compare
// unit, stops at the first hit, then updates that entry where the operation
// calls for it. A miss ends the scan after the last entry. The next request
// can be accepted in the cycle after the result is written.
// A result waiting in the output register does not stop the next request from
// being accepted and scanned; only the final update step waits while the
// receiver stalls and the output register is still full.
// Synchronous reset empties every entry, unlocks them all, sets the id counter
// to one and drops o_out_valid; no clearing pass is needed since occupancy
// lives in per-entry valid flops.
module binary_semaphore_table #(
    parameter int SEM_COUNT = 16,
    parameter int ID_WIDTH  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_func,
    input  logic [bst_pkg::PORT_ID_W-1:0]   i_sem_id,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_status,
    output logic [bst_pkg::PORT_ID_W-1:0]   o_new_id,
    output logic                            o_wake
);

    localparam int IDX_W = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int CNT_W = $clog2(SEM_COUNT + 1);
    localparam int CW    = bst_pkg::CMP_W;
    localparam int PW    = bst_pkg::PORT_ID_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // Control registers.
    t_state                 r_state,     n_state;
    logic [CNT_W-1:0]       r_idx,       n_idx;
    logic                   r_pend,      n_pend;
    logic [SEM_COUNT-1:0]   r_valid,     n_valid;
    logic [SEM_COUNT-1:0]   r_locked,    n_locked;
    logic [ID_WIDTH-1:0]    r_next_id,   n_next_id;
    logic                   r_out_valid, n_out_valid;

    // Payload registers.
    bst_pkg::t_func         r_func,      n_func;
    logic [PW-1:0]          r_tgt,       n_tgt;
    logic [IDX_W-1:0]       r_cmp_idx,   n_cmp_idx;
    logic                   r_found,     n_found;
    logic [IDX_W-1:0]       r_hit_idx,   n_hit_idx;
    bst_pkg::t_status       r_status,    n_status;
    logic [PW-1:0]          r_new_id,    n_new_id;
    logic                   r_wake,      n_wake;

    // Id memory with a registered read port.
    logic [ID_WIDTH-1:0]    r_mem [SEM_COUNT];
    logic [ID_WIDTH-1:0]    r_rd_data;
    logic                   r_rd_occ;

    logic                   in_acc;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   hit;
    logic                   upd_go;
    logic                   wr_en;
    logic [CW-1:0]          given_w;

    assign in_acc  = (r_state == S_IDLE) && i_in_valid;
    assign rd_addr = r_idx[IDX_W-1:0];
    assign rd_en   = (r_state == S_SCAN) && (r_idx < CNT_W'(SEM_COUNT));
    // The final step needs room in the output register.
    assign upd_go  = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
    assign wr_en   = upd_go && (r_func == bst_pkg::FN_ALLOC) && r_found
                     && (r_next_id != '0);
    assign given_w = CW'(r_next_id);

    bst_cmp #(
        .ID_WIDTH (ID_WIDTH)
    ) u_cmp (
        .i_func (r_func),
        .i_tgt  (r_tgt),
        .i_occ  (r_rd_occ),
        .i_data (r_rd_data),
        .o_hit  (hit)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_hit_idx] <= r_next_id;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_occ  <= r_valid[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_valid     = r_valid;
        n_locked    = r_locked;
        n_next_id   = r_next_id;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_tgt       = r_tgt;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_status    = r_status;
        n_new_id    = r_new_id;
        n_wake      = r_wake;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func  = bst_pkg::t_func'(i_func);
                    n_tgt   = i_sem_id;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Issue the read of one entry while comparing the one before.
                n_pend    = rd_en;
                n_cmp_idx = rd_addr;
                n_idx     = r_idx + CNT_W'(1);
                if (r_pend && hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_state   = S_UPD;
                end else if (r_pend && (r_cmp_idx == IDX_W'(SEM_COUNT - 1))) begin
                    n_found = 1'b0;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_out_valid = 1'b1;
                    n_status    = bst_pkg::ST_OK;
                    n_new_id    = '0;
                    n_wake      = 1'b0;
                    n_state     = S_IDLE;
                    if (!r_found) begin
                        n_status = (r_func == bst_pkg::FN_ALLOC) ? bst_pkg::ST_FULL
                                                                 : bst_pkg::ST_NOT_FOUND;
                    end else begin
                        case (r_func)
                            bst_pkg::FN_ALLOC: begin
                                if (r_next_id == '0) begin
                                    n_status = bst_pkg::ST_EXHAUSTED;
                                end else begin
                                    n_new_id             = given_w[PW-1:0];
                                    n_valid[r_hit_idx]   = 1'b1;
                                    n_locked[r_hit_idx]  = 1'b0;
                                    // The counter parks at zero after the largest id.
                                    n_next_id = (&r_next_id) ? '0
                                                             : r_next_id + ID_WIDTH'(1);
                                end
                            end
                            bst_pkg::FN_FREE: begin
                                n_valid[r_hit_idx]  = 1'b0;
                                n_locked[r_hit_idx] = 1'b0;
                            end
                            bst_pkg::FN_DOWN: begin
                                if (r_locked[r_hit_idx]) begin
                                    n_status = bst_pkg::ST_WOULD_BLOCK;
                                end else begin
                                    n_locked[r_hit_idx] = 1'b1;
                                end
                            end
                            default: begin
                                if (r_locked[r_hit_idx]) begin
                                    n_locked[r_hit_idx] = 1'b0;
                                    n_wake              = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_locked    <= '0;
            r_next_id   <= ID_WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_valid     <= n_valid;
            r_locked    <= n_locked;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_tgt     <= n_tgt;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_hit_idx <= n_hit_idx;
        r_status  <= n_status;
        r_new_id  <= n_new_id;
        r_wake    <= n_wake;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_new_id    = r_new_id;
    assign o_wake      = r_wake;

endmodule

// ===== hw/rtl/bst_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the binary semaphore table and its bind statement.
// Depends on bst_pkg for the status codes.
module bst_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic [1:0]                      i_func,
    input logic [bst_pkg::PORT_ID_W-1:0]   i_sem_id,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [2:0]                      o_status,
    input logic [bst_pkg::PORT_ID_W-1:0]   o_new_id,
    input logic                            o_wake
);

    // Reset leaves the block idle with no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    // A request in flight keeps the input side busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled while a request is being handled");

    // Only a successful alloc carries a nonzero id.
    a_id_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_new_id != '0)) |-> (o_status == bst_pkg::ST_OK))
        else $error("new id given with a failing status");

    // Wake comes from an up, which never gives an id.
    a_wake_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wake) |-> ((o_status == bst_pkg::ST_OK) && (o_new_id == '0)))
        else $error("wake raised on a result that is not a clean up");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_new_id) && $stable(o_wake)))
        else $error("stalled result changed");

endmodule

bind binary_semaphore_table bst_checker u_bst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_func      (i_func),
    .i_sem_id    (i_sem_id),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_new_id    (o_new_id),
    .o_wake      (o_wake)
);
